/* rtl/ctlc_pkg.sv */
package ctlc_pkg;

  localparam logic [2:0]  PrefixLen    = 3'd6;
  localparam logic [2:0]  MarkerLen    = 3'd5;
  localparam logic [2:0]  PosMax       = 3'd7;
  localparam logic [3:0]  HexMax       = 4'd8;
  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut    = 32'hFFFF_FFFF;
  localparam logic [7:0]  EndCharReset = 8'h22;
  localparam logic [7:0]  MarkerFirst  = 8'h26;
  localparam int          QueueDepth   = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       scan;
    logic       crc_en;
    logic       snap;
    logic       hex_en;
    logic       hex_valid;
    logic [3:0] hex_digit;
    logic       last;
    logic       start_ok;
    logic       end_ok;
    logic       seen;
  } tok_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h74;
      3'd1:    b = 8'h2E;
      3'd2:    b = 8'h70;
      3'd3:    b = 8'h68;
      3'd4:    b = 8'h70;
      3'd5:    b = 8'h3F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] marker_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = MarkerFirst;
      3'd1:    b = 8'h63;
      3'd2:    b = 8'h72;
      3'd3:    b = 8'h63;
      3'd4:    b = 8'h3D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crc32_tagged_line_checker.sv */
// Checks one text line per frame, one byte per beat with tlast on the final byte. Each line
// gives one result beat: prefix "t.php?" present, final byte equal to end_char, "&crc=" marker
// found at offset 6 or later, and the CRC-32 (reflected, init and xor-out all ones) of the
// bytes between prefix and marker compared with up to eight hex digits after the marker.
// Throughput is one byte per clock while the queue has room, set by the byte-wise CRC update
// in the back end, which is combinational; with the queue and result register free, the final
// byte is pushed into the queue, popped by the back end and registered as the result beat.
// A two-entry queue between the byte classifier and the CRC/hex back end lets input keep
// flowing while a result waits on m_tready. end_char resets to a double quote and may be
// written whenever the block is idle; writes are always accepted, as cfg_ready is tied high.
module crc32_tagged_line_checker
  import ctlc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,    // start_ok, end_ok, marker_seen, crc_ok,
                                  // received_crc[31:0], computed_crc[31:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // end_char
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  tok_t push_data, pop_data;

  ctlc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ctlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ctlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* rtl/ctlc_front.sv */
module ctlc_front
  import ctlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,  // end_char
  output logic       push_valid,
  input  logic       push_ready,
  output tok_t       push_data
);

  logic [7:0] end_char;
  logic [2:0] pos, pos_next;
  logic       pmatch, pmatch_next;
  logic [2:0] mprog, mprog_next;
  logic       found, found_next;
  logic       early, early_next;
  logic       pos_late;
  logic       accept;
  logic [4:0] hex;

  assign cfg_ready  = 1'b1;
  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign accept     = s_tvalid & push_ready;
  assign pos_late   = pos >= PrefixLen;
  assign hex        = hex_decode(s_tdata);

  always_comb begin
    pmatch_next = pmatch;
    if (!pos_late && s_tdata != prefix_byte(pos)) begin
      pmatch_next = 1'b0;
    end
    mprog_next = mprog;
    early_next = early;
    found_next = found;
    if (!found) begin
      if (mprog < MarkerLen && s_tdata == marker_byte(mprog)) begin
        if (mprog == 3'd0) begin
          early_next = !pos_late;
        end
        mprog_next = mprog + 3'd1;
      end else if (s_tdata == MarkerFirst) begin
        early_next = !pos_late;
        mprog_next = 3'd1;
      end else begin
        mprog_next = 3'd0;
      end
      found_next = (mprog_next == MarkerLen);
    end
    pos_next = (pos < PosMax) ? pos + 3'd1 : pos;

    push_data           = '0;
    push_data.data      = s_tdata;
    push_data.scan      = !found;
    push_data.crc_en    = !found && pos_late;
    push_data.snap      = !found && found_next;
    push_data.hex_en    = found && !early;
    push_data.hex_valid = hex[4];
    push_data.hex_digit = hex[3:0];
    push_data.last      = s_tlast;
    push_data.start_ok  = pmatch_next && (pos_next >= PrefixLen);
    push_data.end_ok    = (s_tdata == end_char);
    push_data.seen      = found_next && !early_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char <= EndCharReset;
    end else if (cfg_valid) begin
      end_char <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      pos    <= 3'd0;
      pmatch <= 1'b1;
      mprog  <= 3'd0;
      found  <= 1'b0;
      early  <= 1'b0;
    end else if (accept) begin
      pos    <= pos_next;
      pmatch <= pmatch_next;
      mprog  <= mprog_next;
      found  <= found_next;
      early  <= early_next;
    end
  end

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> pos == 3'd0 && pmatch && !found && mprog == 3'd0)
    else $error("front state not cleared after last beat");

  a_found_holds_marker: assert property (@(posedge clk) disable iff (rst)
    found |-> mprog == MarkerLen)
    else $error("marker found without full marker progress");

endmodule

/* rtl/ctlc_queue.sv */
module ctlc_queue
  import ctlc_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_data
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  tok_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = count != CntW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count overflow");

endmodule

/* rtl/ctlc_back.sv */
module ctlc_back
  import ctlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  tok_t        pop_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);

  logic [31:0] crc_run, crc_run_next;
  logic [31:0] hist [4];
  logic [31:0] crc_mark, crc_mark_next;
  logic [3:0]  hcount, hcount_next;
  logic        hstop, hstop_next;
  logic [31:0] hval, hval_next;
  logic        pop;
  logic [31:0] comp, recv;
  logic        start_ok, end_ok, seen, crc_ok;
  logic [31:0] recv_q, comp_q;

  assign pop_ready = !pop_data.last || !m_tvalid || m_tready;
  assign pop       = pop_valid & pop_ready;

  always_comb begin
    crc_run_next  = pop_data.crc_en ? crc32_byte(crc_run, pop_data.data) : crc_run;
    crc_mark_next = pop_data.snap ? hist[3] : crc_mark;
    hcount_next   = hcount;
    hstop_next    = hstop;
    hval_next     = hval;
    if (pop_data.hex_en && !hstop && hcount < HexMax) begin
      if (!pop_data.hex_valid) begin
        hstop_next = 1'b1;
      end else begin
        hval_next   = {hval[27:0], pop_data.hex_digit};
        hcount_next = hcount + 4'd1;
      end
    end
    comp = pop_data.seen ? (crc_mark_next ^ CrcXorOut) : 32'd0;
    recv = pop_data.seen ? hval_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && pop_data.last)) begin
      crc_run  <= CrcInit;
      crc_mark <= CrcInit;
      hcount   <= 4'd0;
      hstop    <= 1'b0;
      hval     <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        hist[i] <= CrcInit;
      end
    end else if (pop) begin
      crc_run  <= crc_run_next;
      crc_mark <= crc_mark_next;
      hcount   <= hcount_next;
      hstop    <= hstop_next;
      hval     <= hval_next;
      if (pop_data.scan) begin
        hist[0] <= crc_run;
        for (int i = 1; i < 4; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && pop_data.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      start_ok <= pop_data.start_ok;
      end_ok   <= pop_data.end_ok;
      seen     <= pop_data.seen;
      crc_ok   <= pop_data.seen && (recv == comp);
      recv_q   <= recv;
      comp_q   <= comp;
    end
  end

  assign m_tdata = {4'd0, comp_q, recv_q, crc_ok, seen, end_ok, start_ok};

  a_hex_bound: assert property (@(posedge clk) disable iff (rst)
    hcount <= HexMax)
    else $error("hex digit count overflow");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pop && pop_data.last))
    else $error("result raised without a last beat");

  a_crc_ok_needs_seen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && crc_ok |-> seen)
    else $error("crc_ok without marker");

endmodule
